FILE: design/cfce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cfce_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_LEN_OVER  = 2'd1;
  localparam logic [1:0] ST_DATA_OUT  = 2'd2;
  localparam logic [1:0] ST_HDR_IN    = 2'd3;

  localparam logic [2:0] HDR_BYTES  = 3'd5;
  localparam logic [2:0] DATA_BYTES = 3'd1;

  localparam logic [2:0] STEP_ADDR = 3'd2;
  localparam logic [2:0] STEP_CMD  = 3'd3;
  localparam logic [2:0] STEP_LEN  = 3'd4;
  localparam logic [2:0] STEP_HDR  = 3'd0;

  typedef enum logic [1:0] {
    KIND_ERR,
    KIND_HDR,
    KIND_DATA
  } kind_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] dev_addr;
    logic [7:0] command;
    logic [5:0] payload_len;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_last;
    logic [1:0] status;
  } out_word_t;

  typedef struct packed {
    kind_t      kind;
    logic [1:0] status;
    logic [7:0] hdr_val;
    logic [7:0] dev_addr;
    logic [7:0] command;
    logic [5:0] payload_len;
    logic [7:0] data_byte;
    logic       close;
  } cmd_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: design/cfce_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module cfce_fifo
  import cfce_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t wr_data,
  input  wire logic pop,
  output cmd_t      rd_data,
  output logic      not_empty,
  output logic      full
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign rd_data   = slots[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);

endmodule
`default_nettype wire

FILE: design/cfce_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cfce_front
  import cfce_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_word_t in_word,
  input  wire logic [7:0] hdr_val,
  input  wire logic     fifo_full,
  output logic          push,
  output cmd_t          cmd
);

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  logic       frame_open;
  logic       frame_open_next;
  logic [5:0] bytes_left;
  logic [5:0] bytes_left_next;

  assign in_stall = fifo_full;
  assign push     = in_valid && !fifo_full;

  always_comb begin
    cmd             = '0;
    cmd.kind        = KIND_ERR;
    cmd.hdr_val     = hdr_val;
    cmd.dev_addr    = in_word.dev_addr;
    cmd.command     = in_word.command;
    cmd.payload_len = in_word.payload_len;
    cmd.data_byte   = in_word.data_byte;
    frame_open_next = frame_open;
    bytes_left_next = bytes_left;
    if (!in_word.mode) begin
      if (frame_open) begin
        cmd.status = ST_HDR_IN;
      end else if ({2'b00, in_word.payload_len} > MaxLen) begin
        cmd.status = ST_LEN_OVER;
      end else begin
        cmd.kind        = KIND_HDR;
        cmd.status      = ST_OK;
        cmd.close       = (in_word.payload_len == 6'd0);
        frame_open_next = (in_word.payload_len != 6'd0);
        bytes_left_next = in_word.payload_len;
      end
    end else begin
      if (!frame_open) begin
        cmd.status = ST_DATA_OUT;
      end else begin
        cmd.kind        = KIND_DATA;
        cmd.status      = ST_OK;
        cmd.close       = (bytes_left == 6'd1);
        bytes_left_next = bytes_left - 6'd1;
        frame_open_next = (bytes_left != 6'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
      bytes_left <= 6'd0;
    end else if (push) begin
      frame_open <= frame_open_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/cfce_back.sv
`timescale 1ns / 1ps
`default_nettype none
module cfce_back
  import cfce_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t head,
  input  wire logic head_valid,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_word_t out_word
);

  logic [2:0]  step;
  logic [15:0] crc;
  logic [2:0]  n_data;
  logic        advance;
  logic        final_step;
  logic        feed;
  logic        crc_hi;
  logic [7:0]  byte_sel;
  logic [15:0] crc_base;
  out_word_t   word_next;

  assign advance = head_valid && (!out_valid || !out_stall);
  assign pop     = advance && final_step;

  always_comb begin
    n_data     = (head.kind == KIND_HDR) ? HDR_BYTES : DATA_BYTES;
    word_next  = '0;
    final_step = 1'b0;
    feed       = 1'b0;
    crc_hi     = 1'b0;
    byte_sel   = 8'h00;
    unique case (step)
      STEP_HDR:  byte_sel = head.hdr_val;
      STEP_ADDR: byte_sel = head.dev_addr;
      STEP_CMD:  byte_sel = head.command;
      STEP_LEN:  byte_sel = {2'b00, head.payload_len};
      default:   byte_sel = 8'h00;
    endcase
    if (head.kind == KIND_DATA) begin
      byte_sel = head.data_byte;
    end
    if (head.kind == KIND_ERR) begin
      word_next.status = head.status;
      final_step       = 1'b1;
    end else if (step < n_data) begin
      word_next.tx_byte = byte_sel;
      feed              = 1'b1;
      final_step        = (step == n_data - 3'd1) && !head.close;
    end else if (step == n_data) begin
      word_next.tx_byte = crc[7:0];
    end else begin
      word_next.tx_byte    = crc[15:8];
      word_next.frame_last = 1'b1;
      crc_hi               = 1'b1;
      final_step           = 1'b1;
    end
    crc_base = (head.kind == KIND_HDR && step == STEP_HDR) ? CRC_INIT : crc;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= 3'd0;
      crc       <= CRC_INIT;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        step      <= final_step ? 3'd0 : step + 3'd1;
        if (feed) begin
          crc <= crc_feed(crc_base, word_next.tx_byte);
        end else if (crc_hi) begin
          crc <= CRC_INIT;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/crc16_framed_command_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// the first word of an item is offered once the item has been written into the command queue
// and then registered into the output word, when the serializer is idle
// one output word per cycle while out_stall is low; an item yields from 1 to 7 words,
// set by the single-byte output serializer and crc unit
// a 2-entry command queue lets input run ahead of the serializer
// synchronous active-high rst: no frame open, crc at 0xffff, header byte 0
module crc16_framed_command_encoder
  import cfce_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_word_t   in_word,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_word_t       out_word
);

  logic [7:0] header_byte;
  logic       push;
  logic       pop;
  logic       fifo_full;
  logic       fifo_not_empty;
  cmd_t       front_cmd;
  cmd_t       head_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      header_byte <= cfg_data;
    end
  end

  cfce_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .hdr_val  (header_byte),
    .fifo_full(fifo_full),
    .push     (push),
    .cmd      (front_cmd)
  );

  cfce_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data  (front_cmd),
    .pop      (pop),
    .rd_data  (head_cmd),
    .not_empty(fifo_not_empty),
    .full     (fifo_full)
  );

  cfce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head_cmd),
    .head_valid(fifo_not_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  a_last_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.frame_last |-> out_word.status == ST_OK)
    else $error("frame end word carries an error status");

  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.status != ST_OK |-> out_word.tx_byte == 8'h00 && !out_word.frame_last)
    else $error("error word carries frame data");

  a_queue_fill: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> fifo_not_empty)
    else $error("accepted word missing from command queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> fifo_not_empty)
    else $error("command queue popped while empty");

endmodule
`default_nettype wire
